// ===== src/mlp_forward_pass_top_assert.svh =====
// ----------------------------------------------------------------------------
// mlp_forward_pass_top_assert
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef MLP_FORWARD_PASS_TOP_ASSERT_SVH
`define MLP_FORWARD_PASS_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define MFP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define MFP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== src/mfp_pkg.sv =====
// ----------------------------------------------------------------------------
// mfp_pkg
// Shared types and constants of the perceptron forward-pass block.
// ----------------------------------------------------------------------------
package mfp_pkg;
    localparam int MAX_LAYERS = 4;
    localparam int MAX_WIDTH  = 16;
    localparam int VALUE_BITS = 16;
    localparam int FRAC_BITS  = 12;
    localparam int ACC_BITS   = 36;
    localparam int PROD_BITS  = 2 * VALUE_BITS;
    localparam int LAYER_BITS = $clog2(MAX_LAYERS);
    localparam int IDX_BITS   = $clog2(MAX_WIDTH);
    localparam int CNT_BITS   = IDX_BITS + 1;
    localparam int W_DEPTH    = MAX_LAYERS * MAX_WIDTH * MAX_WIDTH;
    localparam int B_DEPTH    = MAX_LAYERS * MAX_WIDTH;
    localparam int A_DEPTH    = 2 * MAX_WIDTH;
    localparam int W_ABITS    = $clog2(W_DEPTH);
    localparam int B_ABITS    = $clog2(B_DEPTH);
    localparam int A_ABITS    = $clog2(A_DEPTH);
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 5;
    localparam int IN_TDATA_BITS = 32;
    localparam int OUT_TDATA_BITS = 24;

    // request kinds
    localparam logic [1:0] REQ_WEIGHT = 2'd0;
    localparam logic [1:0] REQ_BIAS   = 2'd1;
    localparam logic [1:0] REQ_INPUT  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_LAYERS = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INPUTS = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_W0     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_W1     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_W2     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUTS   = 3'd5;

    localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

    // Clamp a count register to 1..max.
    function automatic logic [CNT_BITS-1:0] clamp_cnt(input logic [CFG_DATA_BITS-1:0] v,
                                                      input int maxv);
        logic [CNT_BITS-1:0] r;
        if (v == '0) r = CNT_BITS'(1);
        else if (int'(v) > maxv) r = CNT_BITS'(maxv);
        else r = CNT_BITS'(v);
        return r;
    endfunction

    // Round Q12.24 back to Q4.12 and saturate.
    function automatic logic signed [VALUE_BITS-1:0] to_value(input logic signed [ACC_BITS-1:0] a);
        logic signed [ACC_BITS:0] s;
        logic signed [ACC_BITS-FRAC_BITS:0] q;
        logic signed [VALUE_BITS-1:0] r;
        s = $signed({a[ACC_BITS-1], a}) + $signed((ACC_BITS+1)'(1 << (FRAC_BITS-1)));
        q = s[ACC_BITS:FRAC_BITS];
        if (q > $signed((ACC_BITS-FRAC_BITS+1)'((1 << (VALUE_BITS-1)) - 1)))
            r = {1'b0, {(VALUE_BITS-1){1'b1}}};
        else if (q < -$signed((ACC_BITS-FRAC_BITS+1)'(1 << (VALUE_BITS-1))))
            r = {1'b1, {(VALUE_BITS-1){1'b0}}};
        else
            r = q[VALUE_BITS-1:0];
        return r;
    endfunction

    // Piecewise-linear sigmoid in Q4.12.
    function automatic logic signed [VALUE_BITS-1:0] sigmoid(input logic signed [VALUE_BITS-1:0] x);
        logic [VALUE_BITS:0] a;
        logic [VALUE_BITS:0] y;
        a = x[VALUE_BITS-1] ? (VALUE_BITS+1)'(-$signed({x[VALUE_BITS-1], x}))
                            : (VALUE_BITS+1)'(x);
        if (a >= (VALUE_BITS+1)'(20480))     y = (VALUE_BITS+1)'(4096);
        else if (a >= (VALUE_BITS+1)'(9728)) y = (a >> 5) + (VALUE_BITS+1)'(3456);
        else if (a >= (VALUE_BITS+1)'(4096)) y = (a >> 3) + (VALUE_BITS+1)'(2560);
        else                                 y = (a >> 2) + (VALUE_BITS+1)'(2048);
        if (x[VALUE_BITS-1]) y = (VALUE_BITS+1)'(4096) - y;
        return y[VALUE_BITS-1:0];
    endfunction
endpackage

// ===== src/mfp_ram.sv =====
// ----------------------------------------------------------------------------
// mfp_ram
// Generic single-port-write, registered-read RAM.
// ----------------------------------------------------------------------------
module mfp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/mfp_mac.sv =====
// ----------------------------------------------------------------------------
// mfp_mac
// Shared multiply-accumulate unit: registered product, then saturating add.
// ----------------------------------------------------------------------------
module mfp_mac (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_load,   // load bias<<12 (or zero)
    input  logic signed [mfp_pkg::VALUE_BITS-1:0]  i_bias,
    input  logic                                   i_use_bias,
    input  logic                                   i_mul,    // capture product
    input  logic signed [mfp_pkg::VALUE_BITS-1:0]  i_a,
    input  logic signed [mfp_pkg::VALUE_BITS-1:0]  i_b,
    input  logic                                   i_acc,    // add product
    output logic signed [mfp_pkg::ACC_BITS-1:0]    o_acc
);
    logic signed [mfp_pkg::PROD_BITS-1:0] r_prod;
    logic signed [mfp_pkg::ACC_BITS-1:0]  r_acc, n_acc;
    logic signed [mfp_pkg::ACC_BITS:0]    w_sum;

    always_comb begin
        w_sum = $signed({r_acc[mfp_pkg::ACC_BITS-1], r_acc})
              + (mfp_pkg::ACC_BITS+1)'(r_prod);
        if (w_sum > $signed({1'b0, mfp_pkg::ACC_MAX}))      n_acc = mfp_pkg::ACC_MAX;
        else if (w_sum < $signed({1'b1, mfp_pkg::ACC_MIN})) n_acc = mfp_pkg::ACC_MIN;
        else                                                n_acc = w_sum[mfp_pkg::ACC_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_mul) r_prod <= i_a * i_b;
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_load) begin
            r_acc <= i_use_bias ? (mfp_pkg::ACC_BITS'(i_bias) <<< mfp_pkg::FRAC_BITS) : '0;
        end else if (i_acc) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;
endmodule

// ===== src/mlp_forward_pass_top.sv =====
// ----------------------------------------------------------------------------
// mlp_forward_pass_top
// Multilayer perceptron forward pass on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Weight and bias items are written as they are accepted; the request kind
// travels on s_axis_tuser. An input element with s_axis_tlast set starts a
// pass; the block then drops s_axis_tready until every result has been handed
// over. Each hidden row runs row setup, first read, one product per column
// through the single MAC, drain and write-back; each output row then waits
// in the output state until the output register can take its result.
// Results leave through a one-item output register.
module mlp_forward_pass_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: layer_index[1:0], row_index[5:2], column_index[9:6],
    //        data_value[25:10], zero fill [31:26]
    input  logic [31:0] s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: out_index[3:0], out_value[19:4], zero fill [23:20]
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data
);
    localparam int VB = mfp_pkg::VALUE_BITS;
    localparam int IB = mfp_pkg::IDX_BITS;
    localparam int CB = mfp_pkg::CNT_BITS;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_ROW   = 7'b0000010,
        ST_RD    = 7'b0000100,
        ST_MUL   = 7'b0001000,
        ST_DRAIN = 7'b0010000,
        ST_WB    = 7'b0100000,
        ST_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [2:0] r_layers;
    logic [4:0] r_inputs, r_w0, r_w1, r_w2, r_outs;

    // input fields
    logic [1:0]          w_req;
    logic [1:0]          w_layer;
    logic [IB-1:0]       w_row, w_col;
    logic [VB-1:0]       w_data;
    logic                w_final, w_acc_in;
    assign w_req   = s_axis_tuser;
    assign w_layer = s_axis_tdata[1:0];
    assign w_row   = s_axis_tdata[5:2];
    assign w_col   = s_axis_tdata[9:6];
    assign w_data  = s_axis_tdata[25:10];
    assign w_final = s_axis_tlast;
    assign w_acc_in = s_axis_tvalid && s_axis_tready;

    // sequencer registers
    logic [mfp_pkg::LAYER_BITS-1:0] r_k;
    logic [CB-1:0] r_r, r_c, r_nin, r_nrows, r_nl;
    logic          r_pend;  // output register full
    logic [IB-1:0] r_oidx;
    logic [VB-1:0] r_oval;
    logic          r_olast;

    logic          w_last_layer;
    logic [CB-1:0] w_next_rows;
    assign w_last_layer = (CB'(r_k) + CB'(1) == r_nl);

    always_comb begin
        unique case (r_k)
            2'd0:    w_next_rows = mfp_pkg::clamp_cnt(r_w1, mfp_pkg::MAX_WIDTH);
            default: w_next_rows = mfp_pkg::clamp_cnt(r_w2, mfp_pkg::MAX_WIDTH);
        endcase
    end

    // memories
    logic                          w_wwe, w_bwe, w_awe;
    logic [mfp_pkg::W_ABITS-1:0]   w_wwa, w_wra;
    logic [mfp_pkg::B_ABITS-1:0]   w_bwa, w_bra;
    logic [mfp_pkg::A_ABITS-1:0]   w_awa, w_ara;
    logic [VB-1:0]                 w_awd, w_wq, w_bq, w_aq;
    logic signed [mfp_pkg::ACC_BITS-1:0] w_acc;
    logic [VB-1:0]                 w_rowval;

    assign w_wwe = w_acc_in && (w_req == mfp_pkg::REQ_WEIGHT);
    assign w_bwe = w_acc_in && (w_req == mfp_pkg::REQ_BIAS);
    assign w_wwa = {w_layer, w_row, w_col};
    assign w_bwa = {w_layer, w_row};
    assign w_wra = {r_k, r_r[IB-1:0], r_c[IB-1:0]};
    assign w_bra = {r_k, r_r[IB-1:0]};
    assign w_ara = {r_k[0], r_c[IB-1:0]};
    assign w_rowval = mfp_pkg::sigmoid(mfp_pkg::to_value(w_acc));

    always_comb begin
        if (r_state == ST_WB) begin
            w_awe = !w_last_layer;
            w_awa = {~r_k[0], r_r[IB-1:0]};
            w_awd = w_rowval;
        end else begin
            w_awe = w_acc_in && (w_req == mfp_pkg::REQ_INPUT);
            w_awa = {1'b0, w_col};
            w_awd = w_data;
        end
    end

    mfp_ram #(.WIDTH(VB), .DEPTH(mfp_pkg::W_DEPTH)) u_wram (
        .i_clk(i_clk), .i_we(w_wwe), .i_waddr(w_wwa), .i_wdata(w_data),
        .i_raddr(w_wra), .o_rdata(w_wq));
    mfp_ram #(.WIDTH(VB), .DEPTH(mfp_pkg::B_DEPTH)) u_bram (
        .i_clk(i_clk), .i_we(w_bwe), .i_waddr(w_bwa), .i_wdata(w_data),
        .i_raddr(w_bra), .o_rdata(w_bq));
    mfp_ram #(.WIDTH(VB), .DEPTH(mfp_pkg::A_DEPTH)) u_aram (
        .i_clk(i_clk), .i_we(w_awe), .i_waddr(w_awa), .i_wdata(w_awd),
        .i_raddr(w_ara), .o_rdata(w_aq));

    // MAC controls: products of column c-1 are taken in ST_MUL after the read
    logic r_mul_v, r_add_v;
    mfp_mac u_mac (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_load(r_state == ST_RD), .i_bias(w_bq), .i_use_bias(!w_last_layer),
        .i_mul(r_mul_v), .i_a(w_wq), .i_b(w_aq),
        .i_acc(r_add_v), .o_acc(w_acc));

    assign s_axis_tready = (r_state == ST_IDLE) && !r_pend;
    assign o_cfg_ready   = 1'b1;

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_acc_in && w_req == mfp_pkg::REQ_INPUT && w_final) n_state = ST_ROW;
            ST_ROW:   n_state = ST_RD;
            ST_RD:    n_state = ST_MUL;
            ST_MUL:   if (r_c == r_nin) n_state = ST_DRAIN;
            ST_DRAIN: if (!r_add_v) n_state = ST_WB;
            ST_WB:    n_state = w_last_layer ? ST_OUT : ST_ROW;
            ST_OUT:   if (!r_pend || m_axis_tready) begin
                n_state = (r_r + CB'(1) == r_nrows) ? ST_IDLE : ST_ROW;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_layers <= 3'd1;
            r_inputs <= 5'd16; r_w0 <= 5'd16; r_w1 <= 5'd16;
            r_w2 <= 5'd16; r_outs <= 5'd16;
            r_pend <= 1'b0;
            r_mul_v <= 1'b0;
            r_add_v <= 1'b0;
            r_k <= '0; r_r <= '0; r_c <= '0;
            r_nin <= '0; r_nrows <= '0; r_nl <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    mfp_pkg::CFG_LAYERS: r_layers <= i_cfg_data[2:0];
                    mfp_pkg::CFG_INPUTS: r_inputs <= i_cfg_data;
                    mfp_pkg::CFG_W0:     r_w0 <= i_cfg_data;
                    mfp_pkg::CFG_W1:     r_w1 <= i_cfg_data;
                    mfp_pkg::CFG_W2:     r_w2 <= i_cfg_data;
                    mfp_pkg::CFG_OUTS:   r_outs <= i_cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) r_pend <= 1'b0;
            r_add_v <= r_mul_v;
            r_mul_v <= 1'b0;
            unique case (r_state)
                ST_IDLE: if (n_state == ST_ROW) begin
                    r_k   <= '0;
                    r_r   <= '0;
                    r_nl  <= mfp_pkg::clamp_cnt({2'b00, r_layers}, mfp_pkg::MAX_LAYERS);
                    r_nin <= mfp_pkg::clamp_cnt(r_inputs, mfp_pkg::MAX_WIDTH);
                    r_nrows <= (r_layers <= 3'd1)
                             ? mfp_pkg::clamp_cnt(r_outs, mfp_pkg::MAX_WIDTH)
                             : mfp_pkg::clamp_cnt(r_w0, mfp_pkg::MAX_WIDTH);
                end
                ST_ROW: r_c <= '0;
                ST_RD: begin
                    r_c <= r_c + CB'(1);
                    r_mul_v <= 1'b1;
                end
                ST_MUL: if (r_c != r_nin) begin
                    r_c <= r_c + CB'(1);
                    r_mul_v <= 1'b1;
                end
                ST_WB: if (!w_last_layer) begin
                    if (r_r + CB'(1) == r_nrows) begin
                        r_r   <= '0;
                        r_k   <= r_k + 1'b1;
                        r_nin <= r_nrows;
                        r_nrows <= (CB'(r_k) + CB'(2) == r_nl)
                                 ? mfp_pkg::clamp_cnt(r_outs, mfp_pkg::MAX_WIDTH)
                                 : w_next_rows;
                    end else begin
                        r_r <= r_r + CB'(1);
                    end
                end
                ST_OUT: if (!r_pend || m_axis_tready) begin
                    r_pend  <= 1'b1;
                    r_oidx  <= r_r[IB-1:0];
                    r_oval  <= mfp_pkg::to_value(w_acc);
                    r_olast <= (r_r + CB'(1) == r_nrows);
                    r_r     <= r_r + CB'(1);
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_pend;
    assign m_axis_tdata  = {4'b0000, r_oval, r_oidx};
    assign m_axis_tlast  = r_olast;
endmodule

// ===== src/mfp_checker.sv =====
// ----------------------------------------------------------------------------
// mfp_checker
// Port-level checks of the forward-pass block, bound to the top level.
// ----------------------------------------------------------------------------
`include "mlp_forward_pass_top_assert.svh"
module mfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    // a pass start closes the input side for at least the next cycle
    `MFP_ASSERT_NXT(a_start_busy, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready && s_axis_tuser == mfp_pkg::REQ_INPUT && s_axis_tlast,
        !s_axis_tready, "input accepted right after pass start")
    // never accept input while a result waits
    `MFP_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready,
        "input ready while result pending")
    // a stalled result holds
    `MFP_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed")
    // fill bits stay zero
    `MFP_ASSERT_IMP(a_fill, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[23:20] == 4'd0,
        "fill bits set")
endmodule

bind mlp_forward_pass_top mfp_checker u_mfp_checker (.*);
